// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the expander RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked every clock outside reset.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Implication checked on the following clock outside reset.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- hw/rtl/qbve_pkg.sv -----
// Package with constants and types of the quad expander.
package qbve_pkg;
  localparam int MaxQuads = 8192;
  localparam int TexSlots = 32;
  localparam int SlotW = $clog2(TexSlots);
  localparam int CntW = $clog2(TexSlots + 1);
  localparam int IdxW = $clog2(6 * MaxQuads + 7);
  localparam logic [IdxW-1:0] IdxFull = IdxW'(6 * MaxQuads);
  localparam logic [1:0] CmdBegin = 2'd0;
  localparam logic [1:0] CmdDraw = 2'd1;
  localparam logic [1:0] CmdEnd = 2'd2;
  localparam logic [17:0] SinA = 18'd102944;
  localparam logic [17:0] SinB = 18'd42047;
  localparam logic [17:0] SinC = 18'd4640;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SIN, ST_COS, ST_CHKFULL, ST_SEARCH, ST_ALLOC,
    ST_MUL, ST_EMIT, ST_DRAW
  } state_t;

  typedef enum logic [2:0] {
    SN_IDLE, SN_SQ, SN_C, SN_B, SN_A
  } sin_step_t;

  typedef struct packed {
    logic start;
    logic sel;
    logic [1:0] term;
  } mul_ctl_t;
endpackage

// ----- hw/rtl/quad_batch_vertex_expander_unit.sv -----
// Quad batch vertex expander: one draw command becomes up to five result items.
// Begin scene and unknown commands emit no item; end scene emits one batch item, marked last.
// A draw quad computes sine then cosine, checks the batch, and for each of the four
// corners runs four multiply terms and emits a vertex item; texture 0 skips the slot search.
// A slot search tests the bound slots from slot 1 in turn and binds a new slot if none matches.
// Reset (rst, synchronous) empties the batch: index count 0, one slot bound.
module quad_batch_vertex_expander_unit (
  input logic clk,
  input logic rst,
  input logic in_valid,
  output logic in_stall,
  input logic [1:0] command,
  input logic signed [23:0] center_x,
  input logic signed [23:0] center_y,
  input logic signed [23:0] center_z,
  input logic signed [23:0] width,
  input logic signed [23:0] height,
  input logic [11:0] angle,
  input logic [15:0] texture_id,
  input logic [31:0] rgba,
  input logic [15:0] tiling,
  output logic out_valid,
  input logic out_stall,
  output logic kind,
  output logic signed [23:0] vert_x,
  output logic signed [23:0] vert_y,
  output logic signed [23:0] vert_z,
  output logic [31:0] vert_rgba,
  output logic tex_u,
  output logic tex_v,
  output logic [4:0] slot,
  output logic [15:0] vert_tiling,
  output logic [15:0] batch_indices,
  output logic [5:0] batch_slots,
  output logic last
);
  import qbve_pkg::*;
  `include "assert_macros.svh"

  state_t state, state_next;
  logic [IdxW-1:0] index_total, index_total_next;
  logic [CntW-1:0] slots_used, slots_used_next;
  logic [15:0] slot_tex [TexSlots];
  logic [15:0] slot_rd;
  logic [CntW-1:0] scan, scan_next;
  logic [SlotW-1:0] cur_slot, cur_slot_next;
  logic [1:0] corner, corner_next;
  logic [1:0] term, term_next;
  logic signed [13:0] sin_r, cos_r;
  logic signed [23:0] px, py, pz, w, h;
  logic [15:0] tex, til;
  logic [31:0] col;
  logic [11:0] ang;
  logic tex_wr;
  mul_ctl_t mctl;
  logic signed [13:0] coef;
  logic signed [24:0] offs;
  logic signed [39:0] acc;
  logic signed [24:0] dx, dy;
  logic signed [39:0] rx_r;
  logic load_out;
  logic out_kind, out_last;
  sin_step_t sn_step, sn_step_next;
  logic sn_start, sn_done;
  logic [11:0] sn_a;
  logic [10:0] sn_r;
  logic sn_neg;
  logic [11:0] sn_t2;
  logic [17:0] sn_x, sn_opa, sn_hi, sn_mag;
  logic [11:0] sn_opb;
  logic [29:0] sn_prod;
  logic [12:0] sn_lim;
  logic signed [13:0] sn_res;

  assign in_stall = (state != ST_IDLE) || out_valid;
  assign dx = (corner == 2'd0 || corner == 2'd3) ? -25'(w) : 25'(w);
  assign dy = corner[1] ? 25'(h) : -25'(h);

  assign sn_a = (state == ST_IDLE) ? angle : ang + 12'd1024;
  assign sn_prod = sn_opa * sn_opb;
  assign sn_hi = 18'(sn_prod >> 10);
  assign sn_mag = (sn_hi + 18'd8) >> 4;
  assign sn_lim = (sn_mag > 18'd4096) ? 13'd4096 : sn_mag[12:0];
  assign sn_res = sn_neg ? -$signed({1'b0, sn_lim}) : $signed({1'b0, sn_lim});

  always_comb begin
    sn_step_next = sn_step;
    sn_opa = '0;
    sn_opb = '0;
    case (sn_step)
      SN_IDLE: begin
        if (sn_start) sn_step_next = SN_SQ;
      end
      SN_SQ: begin sn_opa = 18'(sn_r); sn_opb = 12'(sn_r); sn_step_next = SN_C; end
      SN_C: begin sn_opa = SinC; sn_opb = sn_t2; sn_step_next = SN_B; end
      SN_B: begin sn_opa = sn_x; sn_opb = sn_t2; sn_step_next = SN_A; end
      SN_A: begin sn_opa = sn_x; sn_opb = 12'(sn_r); sn_step_next = SN_IDLE; end
      default: sn_step_next = SN_IDLE;
    endcase
  end

  always_comb begin
    mctl = '0;
    coef = cos_r;
    offs = dx;
    // Terms: 0 c*dx, 1 -s*dy (x); 2 s*dx, 3 c*dy (y).
    case (term)
      2'd0: begin coef = cos_r; offs = dx; mctl.start = 1'b1; end
      2'd1: begin coef = sin_r; offs = dy; mctl.term = 2'd1; mctl.sel = 1'b1; end
      2'd2: begin coef = sin_r; offs = dx; mctl.start = 1'b1; end
      2'd3: begin coef = cos_r; offs = dy; mctl.term = 2'd1; end
      default: begin coef = cos_r; offs = dx; end
    endcase
    if (state != ST_MUL) mctl = '0;
  end

  qbve_mac u_mac (.clk(clk), .rst(rst), .ctl(mctl), .coef(coef), .offs(offs), .acc(acc));

  function automatic logic signed [23:0] fin(input logic signed [23:0] p,
                                             input logic signed [39:0] v);
    logic signed [39:0] t;
    logic signed [27:0] s;
    t = (v + 40'sd4096) >>> 13;
    s = 28'(p) + 28'(t);
    if (s > 28'sd8388607) fin = 24'sd8388607;
    else if (s < -28'sd8388608) fin = -24'sd8388608;
    else fin = s[23:0];
  endfunction

  always_comb begin
    state_next = state;
    index_total_next = index_total;
    slots_used_next = slots_used;
    scan_next = scan;
    cur_slot_next = cur_slot;
    corner_next = corner;
    term_next = term;
    tex_wr = 1'b0;
    load_out = 1'b0;
    out_kind = 1'b0;
    out_last = 1'b0;
    sn_start = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_valid && !in_stall) begin
          case (command)
            CmdBegin: begin index_total_next = '0; slots_used_next = CntW'(1); end
            CmdDraw: begin state_next = ST_SIN; sn_start = 1'b1; end
            CmdEnd: begin load_out = 1'b1; out_kind = 1'b1; out_last = 1'b1; end
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_SIN: begin
        if (sn_done) begin
          sn_start = 1'b1;
          state_next = ST_COS;
        end
      end
      ST_COS: begin
        if (sn_done) state_next = ST_CHKFULL;
      end
      ST_CHKFULL: begin
        if (!out_valid) begin
          if (index_total >= IdxFull) begin
            load_out = 1'b1; out_kind = 1'b1;
            index_total_next = '0; slots_used_next = CntW'(1);
          end
          scan_next = CntW'(1);
          cur_slot_next = '0;
          state_next = (tex == 16'd0) ? ST_MUL : ST_SEARCH;
          term_next = '0; corner_next = '0;
        end
      end
      ST_SEARCH: begin
        if (scan >= slots_used || scan >= CntW'(TexSlots)) begin
          state_next = ST_ALLOC;
        end else if (slot_rd == tex) begin
          cur_slot_next = scan[SlotW-1:0];
          state_next = ST_MUL;
        end else begin
          scan_next = scan + CntW'(1);
        end
      end
      ST_ALLOC: begin
        if (!out_valid) begin
          if (slots_used >= CntW'(TexSlots)) begin
            load_out = 1'b1; out_kind = 1'b1;
            index_total_next = '0;
            slots_used_next = CntW'(2);
            cur_slot_next = SlotW'(1);
          end else begin
            cur_slot_next = slots_used[SlotW-1:0];
            slots_used_next = slots_used + CntW'(1);
          end
          tex_wr = 1'b1;
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        term_next = term + 2'd1;
        if (term == 2'd3) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid) begin
          load_out = 1'b1;
          out_last = (corner == 2'd3);
          corner_next = corner + 2'd1;
          if (corner == 2'd3) begin
            index_total_next = index_total + IdxW'(6);
            state_next = ST_IDLE;
          end else begin
            state_next = ST_MUL;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      index_total <= '0;
      slots_used <= CntW'(1);
      out_valid <= 1'b0;
      sn_step <= SN_IDLE;
      sn_done <= 1'b0;
    end else begin
      state <= state_next;
      index_total <= index_total_next;
      slots_used <= slots_used_next;
      sn_step <= sn_step_next;
      sn_done <= (sn_step == SN_A);
      if (load_out) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sn_step == SN_IDLE && sn_start) begin
      sn_r <= sn_a[10] ? 11'd1024 - 11'(sn_a[9:0]) : 11'(sn_a[9:0]);
      sn_neg <= sn_a[11];
    end
    if (sn_step == SN_SQ) sn_t2 <= 12'(sn_prod >> 10);
    if (sn_step == SN_C) sn_x <= SinB - sn_hi;
    if (sn_step == SN_B) sn_x <= SinA - sn_hi;
    if (sn_step == SN_A && state == ST_SIN) sin_r <= sn_res;
    if (sn_step == SN_A && state == ST_COS) cos_r <= sn_res;
  end

  always_ff @(posedge clk) begin
    scan <= scan_next;
    cur_slot <= cur_slot_next;
    corner <= corner_next;
    term <= term_next;
    if (tex_wr) slot_tex[cur_slot_next] <= tex;
    slot_rd <= slot_tex[scan_next[SlotW-1:0]];
    if (state == ST_MUL && term == 2'd2) rx_r <= acc;
    if (state == ST_IDLE && in_valid && !in_stall) begin
      px <= center_x; py <= center_y; pz <= center_z;
      w <= width; h <= height; ang <= angle; tex <= texture_id;
      col <= rgba; til <= tiling;
    end
    if (load_out) begin
      kind <= out_kind;
      last <= out_last;
      if (out_kind) begin
        vert_x <= '0; vert_y <= '0; vert_z <= '0; vert_rgba <= '0;
        tex_u <= 1'b0; tex_v <= 1'b0; slot <= '0; vert_tiling <= '0;
        batch_indices <= 16'(index_total);
        batch_slots <= 6'(slots_used);
      end else begin
        vert_x <= fin(px, rx_r);
        vert_y <= fin(py, acc);
        vert_z <= pz;
        vert_rgba <= col;
        tex_u <= (corner == 2'd1) || (corner == 2'd2);
        tex_v <= corner[1];
        slot <= 5'(cur_slot);
        vert_tiling <= til;
        batch_indices <= '0;
        batch_slots <= '0;
      end
    end
  end

  `ASSERT_IMPL(a_busy_stalls, state != ST_IDLE, in_stall)
  `ASSERT_NEXT(a_slots_bound, state == ST_ALLOC && !out_valid, slots_used >= CntW'(2))
  `ASSERT_IMPL(a_slots_range, 1'b1, slots_used >= CntW'(1) && slots_used <= CntW'(TexSlots))
endmodule

// ----- hw/rtl/qbve_mac.sv -----
// Shared multiply-accumulate unit for the rotated corner offsets.
module qbve_mac (
  input logic clk,
  input logic rst,
  input qbve_pkg::mul_ctl_t ctl,
  input logic signed [13:0] coef,
  input logic signed [24:0] offs,
  output logic signed [39:0] acc
);
  import qbve_pkg::*;
  logic signed [38:0] prod;
  logic signed [39:0] acc_next;
  assign prod = coef * offs;
  always_comb begin
    acc_next = acc;
    if (ctl.start) begin
      acc_next = (ctl.sel) ? -40'(prod) : 40'(prod);
    end else if (ctl.term != 2'd0) begin
      acc_next = ctl.sel ? acc - 40'(prod) : acc + 40'(prod);
    end
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else begin
      acc <= acc_next;
    end
  end
endmodule
